// File: rtl/pit_pkg.sv
// Package for the point-in-triangle unit: widths and shared types.
// No dependencies.
package pit_pkg;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned TolBits      = 16;
  localparam int unsigned QueueDepth   = 4;
endpackage

// File: rtl/pit_front.sv
// Front stage: bounding box screen and difference vectors for one query.
// Depends on pit_pkg.
module pit_front #(
  parameter int unsigned CoordBits = pit_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [pit_pkg::TolBits-1:0]     tol_i,
  input  logic signed [CoordBits-1:0]     ax_i,
  input  logic signed [CoordBits-1:0]     ay_i,
  input  logic signed [CoordBits-1:0]     bx_i,
  input  logic signed [CoordBits-1:0]     by_i,
  input  logic signed [CoordBits-1:0]     cx_i,
  input  logic signed [CoordBits-1:0]     cy_i,
  input  logic signed [CoordBits-1:0]     px_i,
  input  logic signed [CoordBits-1:0]     py_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic                            inbox_o,
  output logic signed [CoordBits:0]       d_o [8]
);
  import pit_pkg::*;
  localparam int unsigned EW = (CoordBits > TolBits ? CoordBits : TolBits) + 2;
  logic signed [EW-1:0] xmin, xmax, ymin, ymax, tol;
  logic inbox;
  logic valid_q;
  logic signed [CoordBits-1:0] xl, xh, yl, yh;

  always_comb begin
    xl = ax_i; xh = ax_i; yl = ay_i; yh = ay_i;
    if (bx_i < xl) xl = bx_i;
    if (cx_i < xl) xl = cx_i;
    if (bx_i > xh) xh = bx_i;
    if (cx_i > xh) xh = cx_i;
    if (by_i < yl) yl = by_i;
    if (cy_i < yl) yl = cy_i;
    if (by_i > yh) yh = by_i;
    if (cy_i > yh) yh = cy_i;
    tol  = EW'(signed'({1'b0, tol_i}));
    xmin = EW'(xl) - tol;
    xmax = EW'(xh) + tol;
    ymin = EW'(yl) - tol;
    ymax = EW'(yh) + tol;
    inbox = !(EW'(px_i) < xmin || EW'(px_i) > xmax ||
              EW'(py_i) < ymin || EW'(py_i) > ymax);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      inbox_o <= inbox;
      d_o[0]  <= (CoordBits+1)'(bx_i) - (CoordBits+1)'(ax_i);
      d_o[1]  <= (CoordBits+1)'(by_i) - (CoordBits+1)'(ay_i);
      d_o[2]  <= (CoordBits+1)'(cx_i) - (CoordBits+1)'(ax_i);
      d_o[3]  <= (CoordBits+1)'(cy_i) - (CoordBits+1)'(ay_i);
      d_o[4]  <= (CoordBits+1)'(px_i) - (CoordBits+1)'(ax_i);
      d_o[5]  <= (CoordBits+1)'(py_i) - (CoordBits+1)'(ay_i);
      d_o[6]  <= (CoordBits+1)'(px_i) - (CoordBits+1)'(bx_i);
      d_o[7]  <= (CoordBits+1)'(py_i) - (CoordBits+1)'(by_i);
    end
  end
endmodule

// File: rtl/pit_back.sv
// Back part: barycentric and edge-distance tests in a stalling pipeline.
// Depends on pit_pkg.
module pit_back #(
  parameter int unsigned CoordBits = pit_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [pit_pkg::TolBits-1:0]   tol_i,
  input  logic                          inbox_i,
  input  logic signed [CoordBits:0]     d_i [8],
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          inside_o,
  output logic                          edge_o
);
  import pit_pkg::*;
  localparam int unsigned DW = CoordBits + 2;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned NE = 3;
  localparam int unsigned CW = CoordBits + 9;
  localparam int unsigned MW = 2 * CoordBits + 17;
  localparam int unsigned QW = 2 * CW;

  // stage 1: edge vectors and point vectors per edge
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                  ib1_q, ib2_q, ib3_q, ib4_q, ib5_q;
  logic signed [DW-1:0]  ex_q [NE], ey_q [NE], vx_q [NE], vy_q [NE];
  logic signed [DW-1:0]  wx_q [NE], wy_q [NE];
  logic signed [DW-1:0]  abx_q, aby_q, acx_q, acy_q, apx_q, apy_q;
  // stage 2: products
  logic signed [PW-1:0]  den_p_q [2], n1_p_q [2], n2_p_q [2];
  logic signed [PW-1:0]  len_p_q [NE][2], dot_p_q [NE][2], cr_p_q [NE][2];
  logic signed [PW-1:0]  vv_p_q [NE][2], ww_p_q [NE][2];
  // stage 3: sums
  logic signed [SW-1:0]  den_q, n1_q, n2_q;
  logic signed [SW-1:0]  len_q [NE], dot_q [NE], cr_q [NE], vv_q [NE], ww_q [NE];
  // stage 4: weight verdict, per-edge class, cross magnitude and limit
  logic                  bary4_q;
  logic [NE-1:0]         pt4_q, usecr4_q, big4_q;
  logic [CW-1:0]         cabs4_q [NE];
  logic [MW-1:0]         lim4_q [NE];
  // stage 5: per-edge decision
  logic                  bary5_q;
  logic [NE-1:0]         near5_q;

  logic adv;
  logic outv_q;
  assign adv     = !outv_q || ready_i;
  assign ready_o = adv;

  logic signed [DW-1:0] dx [8];
  always_comb begin
    for (int i = 0; i < 8; i++) dx[i] = DW'(d_i[i]);
  end

  // |cross| at or above 2^CW can never pass against tol * len
  logic signed [SW-1:0] tols;
  logic signed [SW-1:0] crabs [NE];
  logic [MW-1:0]        lim [NE];
  assign tols = signed'(SW'(tol_i));
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      crabs[e] = cr_q[e] < 0 ? -cr_q[e] : cr_q[e];
      lim[e]   = MW'(tol_i) * MW'(len_q[e][2*CoordBits:0]);
    end
  end

  function automatic logic bary_ok(input logic signed [SW-1:0] den,
                                   input logic signed [SW-1:0] n1,
                                   input logic signed [SW-1:0] n2);
    logic signed [SW:0] s;
    logic ok;
    s = (SW+1)'(n1) + (SW+1)'(n2);
    if (den > 0) ok = (n1 >= 0) && (n2 >= 0) && (s <= (SW+1)'(den));
    else if (den < 0) ok = (n1 <= 0) && (n2 <= 0) && (s >= (SW+1)'(den));
    else ok = 1'b0;
    return ok;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ib1_q <= inbox_i;
      abx_q <= dx[0]; aby_q <= dx[1]; acx_q <= dx[2];
      acy_q <= dx[3]; apx_q <= dx[4]; apy_q <= dx[5];
      // ab: start a end b
      ex_q[0] <= dx[0];          ey_q[0] <= dx[1];
      vx_q[0] <= dx[4];          vy_q[0] <= dx[5];
      wx_q[0] <= dx[6];          wy_q[0] <= dx[7];
      // bc: start b end c
      ex_q[1] <= dx[2] - dx[0];  ey_q[1] <= dx[3] - dx[1];
      vx_q[1] <= dx[6];          vy_q[1] <= dx[7];
      wx_q[1] <= dx[4] - dx[2];  wy_q[1] <= dx[5] - dx[3];
      // ca: start c end a
      ex_q[2] <= -dx[2];         ey_q[2] <= -dx[3];
      vx_q[2] <= dx[4] - dx[2];  vy_q[2] <= dx[5] - dx[3];
      wx_q[2] <= dx[4];          wy_q[2] <= dx[5];

      ib2_q <= ib1_q;
      den_p_q[0] <= PW'(abx_q) * PW'(acy_q);
      den_p_q[1] <= PW'(aby_q) * PW'(acx_q);
      n1_p_q[0]  <= PW'(apx_q) * PW'(acy_q);
      n1_p_q[1]  <= PW'(apy_q) * PW'(acx_q);
      n2_p_q[0]  <= PW'(abx_q) * PW'(apy_q);
      n2_p_q[1]  <= PW'(aby_q) * PW'(apx_q);
      for (int e = 0; e < NE; e++) begin
        len_p_q[e][0] <= PW'(ex_q[e]) * PW'(ex_q[e]);
        len_p_q[e][1] <= PW'(ey_q[e]) * PW'(ey_q[e]);
        dot_p_q[e][0] <= PW'(vx_q[e]) * PW'(ex_q[e]);
        dot_p_q[e][1] <= PW'(vy_q[e]) * PW'(ey_q[e]);
        cr_p_q[e][0]  <= PW'(vx_q[e]) * PW'(ey_q[e]);
        cr_p_q[e][1]  <= PW'(vy_q[e]) * PW'(ex_q[e]);
        vv_p_q[e][0]  <= PW'(vx_q[e]) * PW'(vx_q[e]);
        vv_p_q[e][1]  <= PW'(vy_q[e]) * PW'(vy_q[e]);
        ww_p_q[e][0]  <= PW'(wx_q[e]) * PW'(wx_q[e]);
        ww_p_q[e][1]  <= PW'(wy_q[e]) * PW'(wy_q[e]);
      end

      ib3_q <= ib2_q;
      den_q <= SW'(den_p_q[0]) - SW'(den_p_q[1]);
      n1_q  <= SW'(n1_p_q[0]) - SW'(n1_p_q[1]);
      n2_q  <= SW'(n2_p_q[0]) - SW'(n2_p_q[1]);
      for (int e = 0; e < NE; e++) begin
        len_q[e] <= SW'(len_p_q[e][0]) + SW'(len_p_q[e][1]);
        dot_q[e] <= SW'(dot_p_q[e][0]) + SW'(dot_p_q[e][1]);
        cr_q[e]  <= SW'(cr_p_q[e][0]) - SW'(cr_p_q[e][1]);
        vv_q[e]  <= SW'(vv_p_q[e][0]) + SW'(vv_p_q[e][1]);
        ww_q[e]  <= SW'(ww_p_q[e][0]) + SW'(ww_p_q[e][1]);
      end

      ib4_q <= ib3_q;
      bary4_q <= bary_ok(den_q, n1_q, n2_q);
      for (int e = 0; e < NE; e++) begin
        usecr4_q[e] <= (len_q[e] != 0) && (dot_q[e] >= 0) && (dot_q[e] <= len_q[e]);
        pt4_q[e]    <= (len_q[e] == 0 || dot_q[e] > len_q[e]) ? (ww_q[e] <= tols)
                                                              : (vv_q[e] <= tols);
        big4_q[e]   <= |crabs[e][SW-1:CW];
        cabs4_q[e]  <= crabs[e][CW-1:0];
        lim4_q[e]   <= lim[e];
      end

      ib5_q <= ib4_q;
      bary5_q <= bary4_q;
      for (int e = 0; e < NE; e++) begin
        near5_q[e] <= usecr4_q[e] ?
                      (!big4_q[e] &&
                       (QW'(cabs4_q[e]) * QW'(cabs4_q[e]) <= QW'(lim4_q[e]))) :
                      pt4_q[e];
      end

      inside_o <= ib5_q && (bary5_q || (|near5_q));
      edge_o   <= ib5_q && !bary5_q && (|near5_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      outv_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      outv_q <= v5_q;
    end
  end
  assign valid_o = outv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && edge_o |-> inside_o) else $error("edge without inside");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(inside_o))
    else $error("result lost on stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v4_q)) else $error("pipe moved on stall");
endmodule

// File: rtl/pit_queue.sv
// Small result queue between back pipeline and result port.
// Depends on pit_pkg.
module pit_queue #(
  parameter int unsigned Depth = pit_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] data_o
);
  localparam int unsigned AW = $clog2(Depth);
  logic [1:0]    mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic do_push, do_pop;
  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

// File: rtl/point_in_triangle_with_tolerance_unit.sv
// Top level of the point-in-triangle unit with edge tolerance.
// Depends on pit_pkg, pit_front, pit_back, pit_queue.
// Usage:
//   Input channel: drive a triangle and a query point and raise push;
//   the beat is taken on a clock edge where full is low.
//   Result channel: while empty is low, inside_res_o and edge_hit_o hold
//   the oldest result; raise pop to take it.
//   Tolerance: write through tol_we_i/tol_wdata_i while the unit is idle.
// Path: the result passes the front register, six back pipeline registers
//   and a queue write before it shows on the result port.
// Throughput: one query per cycle while full is low; the back pipeline
//   advances whenever its output register is empty or the queue has room.
// Stall: when the result queue fills, the back pipeline and then the front
//   hold, and full rises; no beat is lost.
// Reset: asynchronous, clears all valid flags and the queue; tolerance 0.
module point_in_triangle_with_tolerance_unit #(
  parameter int unsigned COORD_BITS = pit_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_BITS-1:0]  vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0]  query_x_i,
  input  logic signed [COORD_BITS-1:0]  query_y_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          inside_res_o,
  output logic                          edge_hit_o,
  input  logic                          tol_we_i,
  input  logic [pit_pkg::TolBits-1:0]   tol_wdata_i
);
  import pit_pkg::*;
  logic [TolBits-1:0] tol_q;
  logic f_rdy, f_vld, b_rdy, b_vld, inbox, q_full, ins, edg;
  logic signed [COORD_BITS:0] d [8];
  logic [1:0] qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  assign full = !f_rdy;

  pit_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i(push), .ready_o(f_rdy), .tol_i(tol_q),
    .ax_i(vertex_a_x_i), .ay_i(vertex_a_y_i), .bx_i(vertex_b_x_i),
    .by_i(vertex_b_y_i), .cx_i(vertex_c_x_i), .cy_i(vertex_c_y_i),
    .px_i(query_x_i), .py_i(query_y_i),
    .valid_o(f_vld), .ready_i(b_rdy), .inbox_o(inbox), .d_o(d)
  );

  pit_back #(.CoordBits(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(f_vld), .ready_o(b_rdy), .tol_i(tol_q),
    .inbox_i(inbox), .d_i(d), .valid_o(b_vld), .ready_i(!q_full),
    .inside_o(ins), .edge_o(edg)
  );

  pit_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(b_vld), .data_i({edg, ins}), .full_o(q_full),
    .pop_i(pop), .empty_o(empty), .data_o(qd)
  );
  assign inside_res_o = qd[0];
  assign edge_hit_o   = qd[1];
endmodule
